// ===== rtl/dhb_pkg.sv =====
// Shared types and constants for the decimating history buffer.
// No dependencies.
package dhb_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [31:0] AUTO_STEP = 32'd5;

  // one stored slot
  typedef struct packed {
    logic [31:0] tstamp;
    logic [2:0]  vld;
    logic [15:0] target;
    logic [47:0] temps;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request, resolve time
    logic rd_pair;  // read slots at the pair pointer
    logic wr_merge; // write merged pair
    logic rd_slot;  // read slot for a read request
    logic wr_new;   // write new sample at fill count
    logic finish;   // update count/stamps, load output
  } dhb_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       pair_last;
  } dhb_sts_t;

  // floor((a+b)/2) on signed 16-bit values
  function automatic logic [15:0] avg16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {a[15], a} + {b[15], b};
    return s[16:1];
  endfunction

  function automatic slot_t merge(input slot_t a, input slot_t b);
    slot_t r;
    logic [15:0] x, y;
    logic [31:0] d;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      x = a.temps[16*k +: 16];
      y = b.temps[16*k +: 16];
      if (a.vld[k] && b.vld[k]) r.temps[16*k +: 16] = avg16(x, y);
      else if (a.vld[k]) r.temps[16*k +: 16] = x;
      else if (b.vld[k]) r.temps[16*k +: 16] = y;
      r.vld[k] = a.vld[k] | b.vld[k];
    end
    r.target = avg16(a.target, b.target);
    d = b.tstamp - a.tstamp;
    r.tstamp = a.tstamp + {1'b0, d[31:1]};
    return r;
  endfunction

endpackage

// ===== rtl/dhb_ctrl.sv =====
// Controller state machine for the decimating history buffer.
// Depends on dhb_pkg.
module dhb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              res_free,
  input  dhb_pkg::dhb_sts_t sts,
  output dhb_pkg::dhb_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_PAIR_RD, S_PAIR_WR, S_RD_WAIT, S_WRITE, S_DONE
  } state_t;

  state_t state_r;

  assign req_ready = (state_r == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = req_valid && req_ready;
    cmd.rd_pair  = (state_r == S_PAIR_RD);
    cmd.wr_merge = (state_r == S_PAIR_WR);
    cmd.rd_slot  = (state_r == S_DECODE) && (sts.op == dhb_pkg::OP_READ);
    cmd.wr_new   = (state_r == S_WRITE);
    cmd.finish   = (state_r == S_DONE) && res_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE:    if (req_valid && req_ready) state_r <= S_DECODE;
        S_DECODE: begin
          if (sts.op == dhb_pkg::OP_ADD) state_r <= sts.full ? S_PAIR_RD : S_WRITE;
          else if (sts.op == dhb_pkg::OP_READ) state_r <= S_RD_WAIT;
          else state_r <= S_DONE;
        end
        S_PAIR_RD: state_r <= S_PAIR_WR;
        S_PAIR_WR: state_r <= sts.pair_last ? S_WRITE : S_PAIR_RD;
        S_RD_WAIT: state_r <= S_DONE;
        S_WRITE:   state_r <= S_DONE;
        // hold until the result register is free
        S_DONE:    if (res_free) state_r <= S_IDLE;
        default:   state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/dhb_datapath.sv =====
// Datapath: slot memory, pair merge, stamps and result register.
// Depends on dhb_pkg.
module dhb_datapath #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dhb_pkg::dhb_cmd_t cmd,
  output dhb_pkg::dhb_sts_t sts,
  input  logic [1:0]        op_in,
  input  dhb_pkg::slot_t    slot_in,
  input  logic [7:0]        idx_in,
  input  logic              res_take,
  output logic              res_valid,
  output logic [171:0]      res_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int HALF = DEPTH / 2;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  dhb_pkg::slot_t mem_a [DEPTH];
  dhb_pkg::slot_t mem_b [DEPTH];
  dhb_pkg::slot_t rd_a_r, rd_b_r, new_r, out_slot_r;

  logic [CW-1:0] fill_r;
  logic [31:0]   start_r, end_r, t_res;
  logic [1:0]    op_r;
  logic [7:0]    idx_r;
  logic [AW-1:0] pair_r;
  logic          hit_r, res_valid_r;
  logic [171:0]  res_r;
  logic [CW-1:0] fill_after;
  dhb_pkg::slot_t slot_ld;

  // mem_a and mem_b are identical copies, giving two read ports
  logic [AW:0]   pair_lo, pair_hi;
  logic [AW-1:0] wr_addr, rd0, rd1;
  logic          we;
  dhb_pkg::slot_t wr_data;

  assign pair_lo = {pair_r, 1'b0};
  assign pair_hi = {pair_r, 1'b1};

  always_comb begin
    t_res = slot_in.tstamp;
    if (t_res == 32'hFFFF_FFFF) t_res = (fill_r != '0) ? end_r + dhb_pkg::AUTO_STEP : 32'd0;
    if (fill_r != '0 && t_res < end_r) t_res = end_r;
    slot_ld        = slot_in;
    slot_ld.tstamp = t_res;
  end

  always_comb begin
    we      = cmd.wr_merge || cmd.wr_new;
    wr_addr = cmd.wr_merge ? pair_r : fill_after[AW-1:0];
    wr_data = rd_a_r;
    if (cmd.wr_merge) begin
      if (pair_hi < (AW+1)'(DEPTH)) wr_data = dhb_pkg::merge(rd_a_r, rd_b_r);
    end else begin
      wr_data = new_r;
    end
    rd0 = cmd.rd_slot ? AW'(idx_r) : pair_lo[AW-1:0];
    rd1 = pair_hi[AW-1:0];
  end

  // count seen by the write of the new sample
  assign fill_after = (fill_r >= DEPTH_C) ? CW'(HALF + (DEPTH % 2)) : fill_r;

  function automatic logic [CW-1:0] fill_nxt_val();
    if (op_r == dhb_pkg::OP_ADD) return fill_after + CW'(1);
    if (op_r == dhb_pkg::OP_CLEAR) return '0;
    return fill_r;
  endfunction

  function automatic logic [31:0] start_nxt_val();
    if (op_r == dhb_pkg::OP_ADD) return (fill_r == '0) ? new_r.tstamp : start_r;
    if (op_r == dhb_pkg::OP_CLEAR) return 32'd0;
    return start_r;
  endfunction

  function automatic logic [31:0] end_nxt_val();
    if (op_r == dhb_pkg::OP_ADD) return new_r.tstamp;
    if (op_r == dhb_pkg::OP_CLEAR) return 32'd0;
    return end_r;
  endfunction

  function automatic logic [171:0] res_nxt();
    dhb_pkg::slot_t s;
    logic [8:0] cnt;
    s = '0;
    if (op_r == dhb_pkg::OP_READ && hit_r) s = rd_a_r;
    cnt = 9'(fill_nxt_val());
    return {end_nxt_val(), start_nxt_val(), cnt, s.tstamp, s.vld, s.target, s.temps};
  endfunction

  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[wr_addr] <= wr_data;
      mem_b[wr_addr] <= wr_data;
    end
    if (cmd.rd_pair || cmd.rd_slot) rd_a_r <= mem_a[rd0];
    if (cmd.rd_pair) rd_b_r <= mem_b[rd1];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_in;
      idx_r <= idx_in;
      new_r <= slot_ld;
    end
    if (cmd.rd_slot) hit_r <= (32'(idx_r) < 32'(fill_r));
    if (cmd.finish) res_r <= res_nxt();
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      start_r     <= '0;
      end_r       <= '0;
      pair_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (cmd.load) pair_r <= '0;
      else if (cmd.wr_merge) pair_r <= pair_r + AW'(1);
      if (cmd.finish) begin
        fill_r  <= fill_nxt_val();
        start_r <= start_nxt_val();
        end_r   <= end_nxt_val();
        res_valid_r <= 1'b1;
      end else if (res_take) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  assign sts.op        = op_r;
  assign sts.full      = (fill_r >= DEPTH_C);
  assign sts.pair_last = (pair_hi >= (AW+1)'(DEPTH - 1));
  assign res_valid     = res_valid_r;
  assign res_data      = res_r;

endmodule

// ===== rtl/decimating_history_buffer_unit.sv =====
// Top level of the decimating history buffer.
// Depends on dhb_pkg, dhb_ctrl and dhb_datapath.
//
// Usage:
//  - Requests enter on in_* (tvalid/tready). in_tdata carries operation,
//    temperatures, absent flags, time and slot index; out_* returns one
//    result per request with the read slot, the count and both stamps.
//  - After acceptance a read passes DECODE, RD_WAIT and DONE, a clear DECODE
//    and DONE, an add DECODE, WRITE and DONE; an add that first condenses a
//    full store adds a PAIR_RD/PAIR_WR pass per pair before WRITE.
//  - One request is in flight at a time; the next is taken the cycle after
//    the result is registered. The memory walk of condensing through a
//    single write port makes a condensing add the longest request.
//  - A finished result sits in the output register; the next request is
//    accepted and worked on meanwhile, and waits at its end until that
//    register is free or being emptied in the same cycle.
//  - Reset empties the history (count and stamps zero); memory contents are
//    left as they are, only slots below the count are ever returned.
//  - Slot memory is two mirrored copies so both slots of a pair are read in the same cycle.
module decimating_history_buffer_unit #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[1:0], pit[17:2], probe1[33:18], probe2[49:34], target[65:50],
  // pit_absent[66], probe1_absent[67], probe2_absent[68], time[100:69],
  // slot_index[108:101], zero fill to 112
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pit[15:0], probe1[31:16], probe2[47:32], target[63:48], pit_valid[64],
  // probe1_valid[65], probe2_valid[66], time[98:67], slot_count[107:99],
  // first_time[139:108], last_time[171:140], zero fill to 176
  output logic [175:0] out_tdata
);

  dhb_pkg::dhb_cmd_t cmd;
  dhb_pkg::dhb_sts_t sts;
  dhb_pkg::slot_t    slot_in;
  logic [171:0]      res;
  logic              res_valid;

  // stored layout: pit low, probe2 high; valid flags are inverted absents
  always_comb begin
    slot_in.temps  = {in_tdata[49:34], in_tdata[33:18], in_tdata[17:2]};
    slot_in.target = in_tdata[65:50];
    slot_in.vld    = ~in_tdata[68:66];
    slot_in.tstamp = in_tdata[100:69];
  end

  dhb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .res_free  (!res_valid || out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dhb_datapath #(.DEPTH(HISTORY_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .op_in     (in_tdata[1:0]),
    .slot_in   (slot_in),
    .idx_in    (in_tdata[108:101]),
    .res_take  (out_tready),
    .res_valid (res_valid),
    .res_data  (res)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {4'b0, res};

endmodule

// ===== tb/sv/decimating_history_buffer_unit_tb.sv =====
// Testbench for decimating_history_buffer_unit: directed and random requests
// checked against a behavioural history model. Depends on dhb_pkg and the RTL.
`timescale 1ns / 1ps

module decimating_history_buffer_unit_tb;

  localparam int DEPTH      = 256;
  localparam int CYCLE_CAP  = 1000000;
  localparam int DRAIN_WAIT = DEPTH + 20;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [31:0] last_t;
    logic [31:0] first_t;
    logic [8:0]  count;
    logic [31:0] tstamp;
    logic        p2_vld;
    logic        p1_vld;
    logic        pit_vld;
    logic [15:0] target;
    logic [15:0] probe2;
    logic [15:0] probe1;
    logic [15:0] pit;
  } hist_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [175:0] out_tdata;

  // model state
  logic [15:0] m_pit [DEPTH];
  logic [15:0] m_p1  [DEPTH];
  logic [15:0] m_p2  [DEPTH];
  logic [15:0] m_tgt [DEPTH];
  logic [2:0]  m_vld [DEPTH];
  logic [31:0] m_ts  [DEPTH];
  int unsigned m_count;
  logic [31:0] m_first, m_last;

  hist_result_t pending_results[$];
  int  errors = 0;
  int  cycles = 0;
  int  results_seen = 0;
  int  adds_sent = 0, reads_sent = 0, clears_sent = 0, condenses = 0;
  bit  sink_stall_en = 1'b1;

  decimating_history_buffer_unit #(.HISTORY_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop on hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [15:0] floor_avg(input logic [15:0] a, input logic [15:0] b);
    logic signed [16:0] s;
    s = $signed({a[15], a}) + $signed({b[15], b});
    return s[16:1];
  endfunction

  task automatic merge_one(input int d, input int s);
    logic [2:0] va, vb;
    logic [31:0] diff;
    va = m_vld[s];
    vb = m_vld[s+1];
    m_pit[d] = (va[0] && vb[0]) ? floor_avg(m_pit[s], m_pit[s+1]) :
               va[0] ? m_pit[s] : vb[0] ? m_pit[s+1] : 16'd0;
    m_p1[d]  = (va[1] && vb[1]) ? floor_avg(m_p1[s], m_p1[s+1]) :
               va[1] ? m_p1[s] : vb[1] ? m_p1[s+1] : 16'd0;
    m_p2[d]  = (va[2] && vb[2]) ? floor_avg(m_p2[s], m_p2[s+1]) :
               va[2] ? m_p2[s] : vb[2] ? m_p2[s+1] : 16'd0;
    m_vld[d] = va | vb;
    m_tgt[d] = floor_avg(m_tgt[s], m_tgt[s+1]);
    diff = m_ts[s+1] - m_ts[s];
    m_ts[d] = m_ts[s] + (diff >> 1);
  endtask

  // predict the result of one request and update the model
  task automatic predict_history(input logic [111:0] req);
    hist_result_t r;
    logic [1:0]  op;
    logic [31:0] t;
    int unsigned idx;
    r = '0;
    op = req[1:0];
    if (op == dhb_pkg::OP_ADD) begin
      t = req[100:69];
      if (t == 32'hFFFF_FFFF) t = (m_count != 0) ? m_last + dhb_pkg::AUTO_STEP : 32'd0;
      if (m_count != 0 && t < m_last) t = m_last;
      if (m_count == 0) m_first = t;
      m_last = t;
      if (m_count >= DEPTH) begin
        for (int k = 0; k < DEPTH / 2; k++) merge_one(k, 2 * k);
        m_count = DEPTH / 2;
        condenses++;
      end
      m_pit[m_count] = req[17:2];
      m_p1[m_count]  = req[33:18];
      m_p2[m_count]  = req[49:34];
      m_tgt[m_count] = req[65:50];
      m_vld[m_count] = ~req[68:66];
      m_ts[m_count]  = t;
      m_count++;
    end else if (op == dhb_pkg::OP_READ) begin
      idx = {24'd0, req[108:101]};
      if (idx < m_count) begin
        r.pit = m_pit[idx];  r.probe1 = m_p1[idx];  r.probe2 = m_p2[idx];
        r.target = m_tgt[idx];
        {r.p2_vld, r.p1_vld, r.pit_vld} = m_vld[idx];
        r.tstamp = m_ts[idx];
      end
    end else if (op == dhb_pkg::OP_CLEAR) begin
      m_count = 0;  m_first = '0;  m_last = '0;
    end
    r.count = m_count[8:0];
    r.first_t = m_first;
    r.last_t = m_last;
    pending_results.push_back(r);
  endtask

  // send one request, with a random gap first
  task automatic send_request(input logic [111:0] req);
    int gap;
    gap = $urandom_range(0, 4);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= req;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_history(req);
  endtask

  function automatic logic [111:0] make_req(input logic [1:0] op, input logic [15:0] pit,
      input logic [15:0] p1, input logic [15:0] p2, input logic [15:0] tgt,
      input logic [2:0] absent, input logic [31:0] t, input logic [7:0] idx);
    return {3'b0, idx, t, absent, tgt, p2, p1, pit, op};
  endfunction

  function automatic logic [111:0] rand_req(input logic [1:0] op, input logic [31:0] t);
    return make_req(op, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    3'($urandom_range(0, 7)), t, 8'($urandom));
  endfunction

  function automatic logic [111:0] rand_add(input logic [31:0] t);
    return rand_req(dhb_pkg::OP_ADD, t);
  endfunction

  function automatic logic [111:0] rand_read();
    return rand_req(dhb_pkg::OP_READ, $urandom);
  endfunction

  // result sink with random back-pressure
  initial begin
    hist_result_t exp_r, got;
    int stall;
    forever begin
      @(negedge clk);
      stall = sink_stall_en ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got = out_tdata[171:0];
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.pit !== exp_r.pit || got.probe1 !== exp_r.probe1 ||
            got.probe2 !== exp_r.probe2 || got.target !== exp_r.target)
          begin
          $display("%0t: temps exp %h %h %h %h got %h %h %h %h", $time, exp_r.pit,
                   exp_r.probe1, exp_r.probe2, exp_r.target, got.pit, got.probe1,
                   got.probe2, got.target);
          errors++;
        end
        if ({got.p2_vld, got.p1_vld, got.pit_vld} !==
            {exp_r.p2_vld, exp_r.p1_vld, exp_r.pit_vld}) begin
          $display("%0t: valid exp %b%b%b got %b%b%b", $time, exp_r.p2_vld,
                   exp_r.p1_vld, exp_r.pit_vld, got.p2_vld, got.p1_vld, got.pit_vld);
          errors++;
        end
        if (got.tstamp !== exp_r.tstamp) begin
          $display("%0t: time exp %h got %h", $time, exp_r.tstamp, got.tstamp);
          errors++;
        end
        if (got.count !== exp_r.count) begin
          $display("%0t: count exp %0d got %0d", $time, exp_r.count, got.count);
          errors++;
        end
        if (got.first_t !== exp_r.first_t || got.last_t !== exp_r.last_t) begin
          $display("%0t: stamps exp %h/%h got %h/%h", $time, exp_r.first_t,
                   exp_r.last_t, got.first_t, got.last_t);
          errors++;
        end
      end
    end
  end

  // edge values, auto time, clamping, read past count, unused code
  task automatic test_directed();
    send_request(make_req(dhb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 8'd0));
    send_request(make_req(dhb_pkg::OP_ADD, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                          3'b000, 32'hFFFF_FFFF, 0));
    send_request(make_req(dhb_pkg::OP_ADD, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000,
                          3'b111, 32'hFFFF_FFFF, 0));
    send_request(make_req(dhb_pkg::OP_ADD, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF,
                          3'b101, 32'd1000, 0));
    send_request(make_req(dhb_pkg::OP_ADD, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h0000,
                          3'b010, 32'd3, 0));
    send_request(make_req(dhb_pkg::OP_ADD, 0, 0, 0, 0, 3'b000, 32'hFFFF_FFFE, 0));
    send_request(make_req(dhb_pkg::OP_ADD, 0, 0, 0, 0, 3'b001, 32'hFFFF_FFFF, 0));
    for (int i = 0; i < 7; i++)
      send_request(make_req(dhb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, i[7:0]));
    send_request(make_req(dhb_pkg::OP_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          3'b111, 32'hFFFF_FFFF, 8'hFF));
    send_request(make_req(OP_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111,
                          32'hFFFF_FFFF, 8'hFF));
    send_request(make_req(dhb_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(dhb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 8'd0));
    send_request(make_req(dhb_pkg::OP_ADD, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
                          3'b110, 32'd77, 0));
    send_request(make_req(dhb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 8'd0));
  endtask

  // fill past depth so condensing runs, with a stretch where the result sink does not stall
  task automatic test_condense();
    logic [31:0] t;
    t = $urandom_range(0, 1000);
    sink_stall_en = 1'b0;
    for (int i = 0; i < 300; i++) begin
      t = t + $urandom_range(0, 9);
      case ($urandom_range(0, 9))
        0: send_request(rand_add(32'hFFFF_FFFF));
        1: send_request(rand_add($urandom));
        2: send_request(rand_read());
        default: send_request(rand_add(t));
      endcase
      if (i == 120) sink_stall_en = 1'b1;
    end
  endtask

  // mixed traffic with occasional clears and wrapping times
  task automatic test_random();
    logic [31:0] t;
    t = 32'hFFFF_FF00;
    for (int i = 0; i < 630; i++) begin
      t = t + $urandom_range(0, 20);
      case ($urandom_range(0, 99))
        0:        send_request(rand_req(dhb_pkg::OP_CLEAR, $urandom));
        1:        send_request(rand_req(OP_SPARE, $urandom));
        2, 3, 4:  send_request(rand_add($urandom));
        5, 6:     send_request(rand_add(32'hFFFF_FFFF));
        default:  if ($urandom_range(0, 2) == 0) send_request(rand_read());
                  else send_request(rand_add(t));
      endcase
    end
  endtask

  initial begin
    int wait_cnt;
    m_count = 0;  m_first = '0;  m_last = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_condense();
    test_random();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("Covered %0d adds, %0d reads, %0d clears; %0d condense passes, %0d results",
             adds_sent, reads_sent, clears_sent, condenses, results_seen);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // request mix counters
  always @(posedge clk)
    if (in_tvalid && in_tready)
      case (in_tdata[1:0])
        dhb_pkg::OP_ADD:   adds_sent++;
        dhb_pkg::OP_READ:  reads_sent++;
        dhb_pkg::OP_CLEAR: clears_sent++;
        default:  ;
      endcase

endmodule
